### sv/union_find_path_compression_macros.svh
// Assertion macros shared by the union-find checker.
`ifndef UNION_FIND_PATH_COMPRESSION_MACROS_SVH
`define UNION_FIND_PATH_COMPRESSION_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UFPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UFPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ufpc_pkg.sv
// Types and constants for the union-find table.
`timescale 1ns / 1ps

package ufpc_pkg;

  localparam int NODE_W           = 10;
  localparam int RANK_W           = 4;
  localparam int COUNT_W          = 11;
  localparam int NUM_ELEMENTS_DEF = 1024;
  localparam int IN_TDATA_W       = 24;
  localparam int OUT_TDATA_W      = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

  localparam logic ACT_FIND  = 1'b0;
  localparam logic ACT_UNION = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [RANK_W-1:0] rank_t;

  // One table entry: root flag, rank, parent link.
  typedef struct packed {
    logic  flag;
    rank_t rank;
    node_t parent;
  } ufpc_word_t;

  localparam ufpc_word_t CLEAR_WORD = '{flag: 1'b1, rank: '0, parent: '0};

  typedef struct packed {
    logic  action;
    node_t node_a;
    node_t node_b;
    logic  err;
  } ufpc_cmd_t;

  typedef struct packed {
    node_t root;
    logic  merged;
    logic  status;
  } ufpc_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_START,
    ST_WALK,
    ST_COMP_START,
    ST_COMP,
    ST_FIND_END,
    ST_MERGE,
    ST_BUMP,
    ST_DONE
  } ufpc_state_e;

endpackage

### sv/ufpc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ufpc_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ufpc_core.sv
// Sequencer that walks, compresses and links table entries in one simple dual-port RAM.
`timescale 1ns / 1ps

module ufpc_core import ufpc_pkg::*; #(
  parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF,
  localparam int AW          = $clog2(NUM_ELEMENTS)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  ufpc_cmd_t cmd_i,
  output logic      ready_o,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output ufpc_res_t res_o
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ELEMENTS - 1);

  ufpc_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic  phase_b_q, phase_b_d;
  logic  action_q, action_d;
  node_t node_b_q, node_b_d;
  node_t start_q, start_d;
  node_t cur_q, cur_d;
  node_t top_q, top_d;
  rank_t top_rank_q, top_rank_d;
  node_t ra_q, ra_d, rb_q, rb_d;
  rank_t rank_a_q, rank_a_d, rank_b_q, rank_b_d;
  node_t root_q, root_d;
  logic  merged_q, merged_d;
  logic  status_q, status_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  ufpc_word_t    ram_wdata, ram_rdata;

  // Shared node comparator.
  node_t cmp_x, cmp_y;
  logic  cmp_eq;
  assign cmp_eq = (cmp_x == cmp_y);

  ufpc_ram #(
    .WIDTH($bits(ufpc_word_t)),
    .DEPTH(NUM_ELEMENTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      phase_b_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      phase_b_q <= phase_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    node_b_q   <= node_b_d;
    start_q    <= start_d;
    cur_q      <= cur_d;
    top_q      <= top_d;
    top_rank_q <= top_rank_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    rank_a_q   <= rank_a_d;
    rank_b_q   <= rank_b_d;
    root_q     <= root_d;
    merged_q   <= merged_d;
    status_q   <= status_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    phase_b_d  = phase_b_q;
    action_d   = action_q;
    node_b_d   = node_b_q;
    start_d    = start_q;
    cur_d      = cur_q;
    top_d      = top_q;
    top_rank_d = top_rank_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    rank_a_d   = rank_a_q;
    rank_b_d   = rank_b_q;
    root_d     = root_q;
    merged_d   = merged_q;
    status_d   = status_q;
    ram_we     = 1'b0;
    ram_waddr  = AW'(cur_q);
    ram_wdata  = CLEAR_WORD;
    ram_raddr  = AW'(cur_q);
    cmp_x      = cur_q;
    cmp_y      = top_q;
    ready_o    = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = CLEAR_WORD;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          action_d  = cmd_i.action;
          node_b_d  = cmd_i.node_b;
          phase_b_d = 1'b0;
          merged_d  = 1'b0;
          if (cmd_i.err) begin
            root_d   = '0;
            status_d = STATUS_RANGE;
            state_d  = ST_DONE;
          end else begin
            status_d = STATUS_OK;
            start_d  = cmd_i.node_a;
            cur_d    = cmd_i.node_a;
            state_d  = ST_FIND_START;
          end
        end
      end
      ST_FIND_START: begin
        ram_raddr = AW'(cur_q);
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        // One link per cycle: the next address comes straight off the read data.
        if (ram_rdata.flag) begin
          top_d      = cur_q;
          top_rank_d = ram_rdata.rank;
          cur_d      = start_q;
          state_d    = ST_COMP_START;
        end else begin
          cur_d     = ram_rdata.parent;
          ram_raddr = AW'(ram_rdata.parent);
        end
      end
      ST_COMP_START: begin
        if (cmp_eq) begin
          state_d = ST_FIND_END;
        end else begin
          ram_raddr = AW'(cur_q);
          state_d   = ST_COMP;
        end
      end
      ST_COMP: begin
        // Point cur at the root while fetching its old parent.
        cmp_x = ram_rdata.parent;
        if (ram_rdata.flag) begin
          state_d = ST_FIND_END;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cur_q);
          ram_wdata = '{flag: 1'b0, rank: ram_rdata.rank, parent: top_q};
          cur_d     = ram_rdata.parent;
          if (cmp_eq) begin
            state_d = ST_FIND_END;
          end else begin
            ram_raddr = AW'(ram_rdata.parent);
          end
        end
      end
      ST_FIND_END: begin
        if (!phase_b_q) begin
          ra_d     = top_q;
          rank_a_d = top_rank_q;
          if (action_q == ACT_FIND) begin
            root_d  = top_q;
            state_d = ST_DONE;
          end else begin
            phase_b_d = 1'b1;
            start_d   = node_b_q;
            cur_d     = node_b_q;
            state_d   = ST_FIND_START;
          end
        end else begin
          rb_d     = top_q;
          rank_b_d = top_rank_q;
          state_d  = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmp_x    = ra_q;
        cmp_y    = rb_q;
        merged_d = !cmp_eq;
        root_d   = ra_q;
        state_d  = ST_DONE;
        if (!cmp_eq) begin
          ram_we = 1'b1;
          if (rank_a_q >= rank_b_q) begin
            ram_waddr = AW'(rb_q);
            ram_wdata = '{flag: 1'b0, rank: rank_b_q, parent: ra_q};
            if (rank_a_q == rank_b_q) begin
              state_d = ST_BUMP;
            end
          end else begin
            ram_waddr = AW'(ra_q);
            ram_wdata = '{flag: 1'b0, rank: rank_a_q, parent: rb_q};
            root_d    = rb_q;
          end
        end
      end
      ST_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ra_q);
        ram_wdata = '{flag: 1'b1,
                      rank: (rank_a_q == RANK_MAX) ? RANK_MAX : rank_a_q + rank_t'(1),
                      parent: '0};
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = '{root: root_q, merged: merged_q, status: status_q};

endmodule

### sv/union_find_path_compression.sv
// Top level of the union-find table: config register, range check, output stage.
//
//  Channel  Role    Handshake                  Payload
//  s_axis   input   s_axis_tvalid/tready       tuser: action; tdata: node_a, node_b
//  m_axis   output  m_axis_tvalid/tready       tuser: status; tdata: root, merged
//  cfg      config  cfg_we_i (no wait)         cfg_wdata_i: element_count
//
//  A find walks from node_a to its root, then points every node on that path at the
//  root; a union does this for node_a and then node_b, links the two roots, and adds
//  a rank-bump step when the two root ranks tie. The single RAM read port bounds the
//  work: the walk follows one link a cycle, and compression rewrites one a cycle. An
//  out-of-range item goes straight to its result. s_axis_tready rises again in the
//  cycle after the core hands its result on. After reset a clearing pass marks every
//  entry a root of rank 0; no item is accepted meanwhile, config writes are.
//  The output register lets the next item enter while a result waits on m_axis_tready.
`timescale 1ns / 1ps

module union_find_path_compression import ufpc_pkg::*; #(
  parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] node_a, [19:10] node_b, zero pad
  input  logic                   s_axis_tuser,  // [0] action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [9:0] root, [10] merged, zero pad
  output logic                   m_axis_tuser,  // [0] status
  input  logic                   cfg_we_i,
  input  logic [COUNT_W-1:0]     cfg_wdata_i
);

  localparam int CMP_W = 17;

  logic [COUNT_W-1:0] count_q;
  ufpc_cmd_t          cmd;
  logic               core_ready, core_res_valid, core_res_ready;
  ufpc_res_t          core_res;
  logic               out_valid_q;
  ufpc_res_t          out_q;
  logic               a_bad, b_bad;

  // Hold the element count; the range check reads it as an item transfers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Flag any index at or above min(element_count, NUM_ELEMENTS) as out of range.
  assign a_bad = (CMP_W'(s_axis_tdata[NODE_W-1:0]) >= CMP_W'(count_q)) ||
                 (CMP_W'(s_axis_tdata[NODE_W-1:0]) >= CMP_W'(NUM_ELEMENTS));
  assign b_bad = (CMP_W'(s_axis_tdata[2*NODE_W-1:NODE_W]) >= CMP_W'(count_q)) ||
                 (CMP_W'(s_axis_tdata[2*NODE_W-1:NODE_W]) >= CMP_W'(NUM_ELEMENTS));

  assign cmd = '{action: s_axis_tuser,
                 node_a: s_axis_tdata[NODE_W-1:0],
                 node_b: s_axis_tdata[2*NODE_W-1:NODE_W],
                 err:    a_bad || ((s_axis_tuser == ACT_UNION) && b_bad)};

  assign s_axis_tready = core_ready;

  ufpc_core #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid),
    .cmd_i      (cmd),
    .ready_o    (core_ready),
    .res_valid_o(core_res_valid),
    .res_ready_i(core_res_ready),
    .res_o      (core_res)
  );

  // Output register: advance when empty or when the current result transfers.
  assign core_res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_ready && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - NODE_W - 1)'(0), out_q.merged, out_q.root};
  assign m_axis_tuser  = out_q.status;

endmodule

### sv/ufpc_checker.sv
// Port-level checks for the union-find table, bound to the top level.
`timescale 1ns / 1ps
`include "union_find_path_compression_macros.svh"

module ufpc_checker import ufpc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // An error result carries no root and no merge.
  `UFPC_ASSERT_NOW(a_err_clean, m_axis_tvalid && (m_axis_tuser == STATUS_RANGE), m_axis_tdata[NODE_W:0] == '0, "error result with nonzero root or merged")

  // Padding above merged stays zero.
  `UFPC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:NODE_W+1] == '0, "nonzero tdata padding")

  // One item in work at a time: ready drops after every input transfer.
  `UFPC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready held after input transfer")

  // A stalled result holds.
  `UFPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind union_find_path_compression ufpc_checker u_ufpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

### test/tb_union_find_path_compression.sv
// Self-checking testbench for the union-find table with path compression.
`timescale 1ns / 1ps

module tb_union_find_path_compression;
  import ufpc_pkg::*;

  localparam int NUM_NODES  = NUM_ELEMENTS_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 64;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [9:0] node_a, [19:10] node_b, zero pad
  logic                   s_axis_tuser;   // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [9:0] root, [10] merged, zero pad
  logic                   m_axis_tuser;   // [0] status
  logic                   cfg_we_i;
  logic [COUNT_W-1:0]     cfg_wdata_i;

  union_find_path_compression #(.NUM_ELEMENTS(NUM_NODES)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the disjoint-set table and the element count.
  node_t            set_parent [NUM_NODES];
  bit               set_is_root[NUM_NODES];
  rank_t            set_rank   [NUM_NODES];
  logic [COUNT_W-1:0] set_count;

  ufpc_res_t pending_results[$];

  int  mismatches;
  int  items_sent;
  int  results_seen;
  int  merges_seen;
  int  range_errors;
  int  count_settings;
  int  idle_cycles;
  int  hold_left;
  int  stall_left;
  bit  steady;

  function automatic node_t locate_root(input node_t n);
    node_t top;
    node_t cur;
    node_t nxt;
    int    steps;
    top   = n;
    steps = 0;
    while (!set_is_root[top] && steps < NUM_NODES) begin
      top = set_parent[top];
      steps++;
    end
    // point every node on the path straight at the root
    cur   = n;
    steps = 0;
    while (cur != top && !set_is_root[cur] && steps < NUM_NODES) begin
      nxt             = set_parent[cur];
      set_parent[cur] = top;
      cur             = nxt;
      steps++;
    end
    return top;
  endfunction

  function automatic ufpc_res_t apply_set_op(input logic act, input node_t a, input node_t b);
    ufpc_res_t res;
    int        active;
    node_t     ra;
    node_t     rb;
    active     = (set_count < NUM_NODES) ? int'(set_count) : NUM_NODES;
    res.root   = '0;
    res.merged = 1'b0;
    res.status = STATUS_OK;
    if (int'(a) >= active || (act == ACT_UNION && int'(b) >= active)) begin
      res.status = STATUS_RANGE;
      return res;
    end
    ra       = locate_root(a);
    res.root = ra;
    if (act == ACT_UNION) begin
      rb = locate_root(b);
      if (ra != rb) begin
        res.merged = 1'b1;
        if (set_rank[ra] >= set_rank[rb]) begin
          set_parent[rb]  = ra;
          set_is_root[rb] = 1'b0;
          if (set_rank[ra] == set_rank[rb] && set_rank[ra] < RANK_MAX)
            set_rank[ra] = set_rank[ra] + 1'b1;
        end else begin
          set_parent[ra]  = rb;
          set_is_root[ra] = 1'b0;
          res.root        = rb;
        end
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until the transfer, then record its expected result.
  task automatic send_item(input logic act, input node_t a, input node_t b);
    int        gap;
    ufpc_res_t exp_res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 2 * NODE_W){1'b0}}, b, a};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_res         = apply_set_op(act, a, b);
    pending_results = {pending_results, exp_res};
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    set_count = value;
    count_settings++;
  endtask

  task automatic test_directed_ops();
    send_item(ACT_FIND,  10'd0,    10'd1023);
    send_item(ACT_FIND,  10'd1023, 10'd0);
    send_item(ACT_UNION, 10'd0,    10'd1023);  // equal ranks
    send_item(ACT_UNION, 10'd1023, 10'd0);     // same set, no merge
    send_item(ACT_FIND,  10'd1023, 10'd1023);
    send_item(ACT_UNION, 10'd5,    10'd6);
    send_item(ACT_UNION, 10'd7,    10'd5);     // lower rank goes under
    send_item(ACT_UNION, 10'd20,   10'd21);
    send_item(ACT_UNION, 10'd22,   10'd23);
    send_item(ACT_UNION, 10'd20,   10'd22);
    send_item(ACT_UNION, 10'd5,    10'd20);    // rank 1 under rank 2
    send_item(ACT_FIND,  10'd7,    10'd0);     // long path, compress it
    send_item(ACT_FIND,  10'd23,   10'd0);
    send_item(ACT_UNION, 10'd1023, 10'd23);
    send_item(ACT_FIND,  10'd1023, 10'd1023);
    drain_results();
  endtask

  task automatic test_range_limits();
    write_count(11'd2);
    send_item(ACT_FIND,  10'd2,    10'd0);
    send_item(ACT_UNION, 10'd0,    10'd2);
    send_item(ACT_UNION, 10'd1023, 10'd1);
    send_item(ACT_UNION, 10'd0,    10'd1);
    drain_results();
    write_count(11'd1);
    send_item(ACT_UNION, 10'd0,    10'd0);
    send_item(ACT_FIND,  10'd1,    10'd0);
    drain_results();
    write_count(11'd0);
    send_item(ACT_FIND,  10'd0,    10'd0);
    send_item(ACT_UNION, 10'd0,    10'd0);
    drain_results();
    write_count(11'd2047);                    // clamps to the table size
    send_item(ACT_FIND,  10'd1023, 10'd0);
    send_item(ACT_UNION, 10'd1022, 10'd1023);
    drain_results();
  endtask

  // Mostly unions and finds inside a narrow window so sets grow deep, plus noise.
  task automatic test_random_phase(input logic [COUNT_W-1:0] cnt, input int n_items,
                                   input int span, input bit quiet);
    int    active;
    int    lo;
    int    k;
    node_t a;
    node_t b;
    logic  act;
    write_count(cnt);
    steady = quiet;
    active = (cnt < NUM_NODES) ? int'(cnt) : NUM_NODES;
    for (k = 0; k < n_items; k++) begin
      if (k % 50 == 0)
        lo = (active > span) ? $urandom_range(0, active - span) : 0;
      act = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        a = node_t'($urandom_range(0, NUM_NODES - 1));
        b = node_t'($urandom_range(0, NUM_NODES - 1));
      end else begin
        a = node_t'(lo + $urandom_range(0, span - 1));
        b = node_t'(lo + $urandom_range(0, span - 1));
      end
      send_item(act, a, b);
    end
    drain_results();
    steady = 1'b0;
  endtask

  // Hold the receiver off long enough that the block stalls its input.
  task automatic test_backpressure();
    int k;
    steady    = 1'b1;
    hold_left = 400;
    for (k = 0; k < 24; k++)
      send_item(1'($urandom_range(0, 1)), node_t'($urandom_range(0, 31)),
                node_t'($urandom_range(0, 31)));
    drain_results();
    steady = 1'b0;
  endtask

  // Let the output side empty out completely between items.
  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 8; k++) begin
      send_item(1'($urandom_range(0, 1)), node_t'($urandom_range(0, 63)),
                node_t'($urandom_range(0, 63)));
      drain_results();
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NUM_NODES; i++) begin
      set_parent[i]  = '0;
      set_is_root[i] = 1'b1;
      set_rank[i]    = '0;
    end
    set_count      = COUNT_RESET;
    mismatches     = 0;
    items_sent     = 0;
    results_seen   = 0;
    merges_seen    = 0;
    range_errors   = 0;
    count_settings = 0;
    idle_cycles    = 0;
    hold_left      = 0;
    stall_left     = 0;
    steady         = 1'b0;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    test_range_limits();
    test_random_phase(11'd1024, 400, 48,   1'b0);
    test_backpressure();
    test_random_phase(11'd2047, 150, 1024, 1'b0);
    test_random_phase(11'd64,   300, 64,   1'b0);
    test_sender_pause();
    test_random_phase(11'd16,   200, 16,   1'b1);
    test_random_phase(11'd3,    100, 3,    1'b0);
    test_random_phase(11'd1,    60,  1,    1'b0);
    test_random_phase(11'd0,    40,  1,    1'b0);
    test_random_phase(11'd1000, 300, 40,   1'b0);
    test_random_phase(11'd1024, 200, 1024, 1'b0);

    $display("Covered %0d items over %0d element-count settings: %0d results checked,",
             items_sent, count_settings, results_seen);
    $display("%0d merging unions, %0d out-of-range items, %0d mismatches.",
             merges_seen, range_errors, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, short mostly, plus a long hold when a test asks.
  initial begin
    int r;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    ufpc_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.merged) merges_seen++;
        if (want.status == STATUS_RANGE) range_errors++;
        if (m_axis_tdata[NODE_W-1:0] !== want.root) begin
          $error("root: expected %0d, got %0d", want.root, m_axis_tdata[NODE_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[NODE_W] !== want.merged) begin
          $error("merged: expected %0d, got %0d", want.merged, m_axis_tdata[NODE_W]);
          mismatches++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

### files.f
+incdir+sv
sv/ufpc_pkg.sv
sv/ufpc_ram.sv
sv/ufpc_core.sv
sv/union_find_path_compression.sv
sv/ufpc_checker.sv
test/tb_union_find_path_compression.sv
